// ===== hdl/lnf_pkg.sv =====
// Shared constants, types and elaboration-time helpers for the niel fraction unit.
package lnf_pkg;

  localparam int OUT_FRAC_BITS_DEF = 16;
  localparam int ENERGY_BITS_DEF   = 32;

  // Log domain: base-2 logs with 16 fractional bits
  localparam int LOG_FRAC     = 16;
  localparam int LOG_ONE      = 1 << LOG_FRAC;
  localparam int ENERGY_FRAC  = 16;
  localparam int MANT_W       = 31;
  localparam int LOG_SQ_STEPS = 16;
  localparam int LOG_STAGES   = LOG_SQ_STEPS + 2;
  localparam int LW           = 26;

  // Configuration registers
  localparam int Z_BITS     = 15;
  localparam int A_BITS     = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int ZA_FRAC    = 8;
  localparam int ZA_MIN     = 256;
  localparam logic [Z_BITS-1:0] Z_RESET = 15'd8192;
  localparam logic [A_BITS-1:0] A_RESET = 17'd18432;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATERIAL_PRESENT = 2'd0,
    REG_Z_EFF            = 2'd1,
    REG_A_EFF            = 2'd2
  } lnf_reg_t;

  // Exponent scalings
  localparam int Z_EPS_NUM = 7;
  localparam int Z_EPS_DEN = 3;
  localparam int Z_K_NUM   = 2;
  localparam int Z_K_DEN   = 3;
  localparam int EPS_A_NUM = 3;
  localparam int EPS_A_DEN = 5;
  localparam int EPS_B_DEN = 20;
  localparam int CD_W      = 24;

  // exp2 polynomial and output scaling
  localparam int POLY_A     = 5206;
  localparam int POLY_B     = 14712;
  localparam int POLY_C     = 45618;
  localparam int P_W        = 17;
  localparam int EXP_SH_OFS = 16;
  localparam int EXP_SH_MAX = 39;
  localparam int EXP_CAP_BIT = 56;
  localparam int EXP_W      = EXP_CAP_BIT + 1;
  localparam int D_ONE_BIT  = 32;
  localparam int DW         = 58;

  typedef struct packed {
    logic no_mat;
    logic zero;
  } lnf_flags_t;

  // log2 of a raw integer in Q.16, same squaring scheme as the hardware
  function automatic int lg_const(input longint unsigned x);
    int e;
    longint unsigned m;
    int frac;
    e = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) e = i;
    end
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    frac = 0;
    for (int i = 0; i < LOG_SQ_STEPS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return e * LOG_ONE + frac;
  endfunction

  localparam int LG_EPS = lg_const(64'd49392124) - 32 * LOG_ONE;
  localparam int LG_K   = lg_const(64'd571230650) - 32 * LOG_ONE;
  localparam int LG_07  = lg_const(64'd45875) - 16 * LOG_ONE;
  localparam int LG_3   = lg_const(64'd196608) - 16 * LOG_ONE;

endpackage

// ===== hdl/lnf_log.sv =====
// Pipelined base-2 logarithm: msb search, normalize, sixteen squaring stages.
module lnf_log
  import lnf_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                          clk,
  input  logic [LOG_STAGES-1:0]         en,
  input  logic [W-1:0]                  x_i,
  output logic [$clog2(W)+LOG_FRAC-1:0] lg_o
);

  localparam int EB = $clog2(W);

  logic [W-1:0]        x_r;
  logic [EB-1:0]       e_r    [LOG_STAGES];
  logic [MANT_W-1:0]   m_r    [1:LOG_STAGES-1];
  logic [LOG_FRAC-1:0] frac_r [2:LOG_STAGES-1];
  logic [EB-1:0]       msb;

  always_comb begin
    msb = '0;
    for (int i = 0; i < W; i++) begin
      if (x_i[i]) msb = EB'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r    <= x_i;
      e_r[0] <= msb;
    end
  end

  // normalize to Q1.30
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_r[1] <= MANT_W'({x_r, (MANT_W-1)'(0)} >> e_r[0]);
      e_r[1] <= e_r[0];
    end
  end

  for (genvar k = 2; k < LOG_STAGES; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     s;
    logic [LOG_FRAC-1:0] fprev;

    if (k == 2) begin : g_first
      assign fprev = '0;
    end else begin : g_next
      assign fprev = frac_r[k-1];
    end

    assign sq = (2*MANT_W)'(m_r[k-1]) * (2*MANT_W)'(m_r[k-1]);
    assign s  = sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        e_r[k]    <= e_r[k-1];
        m_r[k]    <= s[MANT_W] ? s[MANT_W:1] : s[MANT_W-1:0];
        frac_r[k] <= {fprev[LOG_FRAC-2:0], s[MANT_W]};
      end
    end
  end

  assign lg_o = {e_r[LOG_STAGES-1], frac_r[LOG_STAGES-1]};

endmodule

// ===== hdl/lnf_div.sv =====
// Pipelined restoring divider: 2^(F+32) / d, one quotient bit per stage.
module lnf_div
  import lnf_pkg::*;
#(
  parameter int F = 16
) (
  input  logic          clk,
  input  logic [F:0]    en,
  input  logic [DW-1:0] d_i,
  output logic [F:0]    q_o,
  output logic          rem_nz_o
);

  localparam int RW = F + D_ONE_BIT + 1;
  localparam int MW = (RW > DW) ? RW : DW;

  logic [RW-1:0] rem_r [F+1];
  logic [F:0]    q_r   [F+1];
  logic [DW-1:0] d_r   [F];

  for (genvar k = 0; k <= F; k++) begin : g_bit
    localparam int I = F - k;
    localparam logic [RW-1:0] LOWM = (RW'(1) << I) - RW'(1);

    logic [RW-1:0] rem_in;
    logic [F:0]    q_in;
    logic [DW-1:0] d_in;
    logic [MW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = RW'(1) << (F + D_ONE_BIT);
      assign q_in   = '0;
      assign d_in   = d_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign d_in   = d_r[k-1];
    end

    // one subtract gives both the compare and the new remainder
    assign diff = {1'b0, MW'(rem_in >> I)} - {1'b0, MW'(d_in)};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (!diff[MW]) begin
          rem_r[k] <= (RW'(diff[MW-1:0]) << I) | (rem_in & LOWM);
          q_r[k]   <= q_in | ((F+1)'(1) << I);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end

    if (k < F) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) d_r[k] <= d_in;
      end
    end
  end

  assign q_o      = q_r[F];
  assign rem_nz_o = |rem_r[F];

endmodule

// ===== hdl/lindhard_niel_fraction_unit.sv =====
// Top level: non-ionizing energy fraction of a nuclear recoil, fully pipelined.
//
// Input channel in_valid/in_ready carries one recoil energy (unsigned Q16.16)
// per request; the output channel out_valid/out_ready returns the fraction in
// Q1.OUT_FRAC_BITS plus the no_material flag, one result per request, in order.
// Material Z and A and the material_present bit are written through cfg_we,
// cfg_index, cfg_wdata; the user must write them only while no request is in
// flight (the block does not enforce this); each request samples them on entry.
// The path from acceptance to out_valid runs through 18 log stages, exponent
// scaling with constant dividers, a four stage exp2 per term, a sum stage, one
// divider stage per quotient bit and the output register. A new request is
// taken every cycle while out_ready is high.
// Each stage holds its own valid bit; a stalled receiver freezes only the full
// stages behind the output register, bubbles keep closing up, and in_ready
// falls only once every stage holds a request.
// Reset clears all valid bits and loads the configuration defaults (no
// material, Z = 32, A = 72).
module lindhard_niel_fraction_unit
  import lnf_pkg::*;
#(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  parameter int ENERGY_BITS   = ENERGY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ENERGY_BITS-1:0] in_recoil_energy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_FRAC_BITS:0] out_niel_fraction,
  output logic                   out_no_material,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int F       = OUT_FRAC_BITS;
  localparam int ST_P1   = LOG_STAGES;
  localparam int ST_CD1  = ST_P1 + 1;
  localparam int ST_EPS  = ST_CD1 + 2;
  localparam int ST_ABS  = ST_EPS + 1;
  localparam int ST_CD2  = ST_ABS + 1;
  localparam int ST_ARG  = ST_CD2 + 2;
  localparam int ST_EXP  = ST_ARG + 1;
  localparam int ST_SUM  = ST_EXP + 4;
  localparam int ST_DIV  = ST_SUM + 1;
  localparam int ST_OUT  = ST_DIV + F + 1;
  localparam int NSTAGE  = ST_OUT + 1;
  localparam int ELG_W   = $clog2(ENERGY_BITS) + LOG_FRAC;
  localparam int ZLG_W   = $clog2(Z_BITS) + LOG_FRAC;
  localparam int ALG_W   = $clog2(A_BITS) + LOG_FRAC;
  localparam int NW      = LW - LOG_FRAC;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  // configuration
  logic              material_present_r;
  logic [Z_BITS-1:0] z_eff_r;
  logic [A_BITS-1:0] a_eff_r;
  logic [Z_BITS-1:0] z_clip;
  logic [A_BITS-1:0] a_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      material_present_r <= 1'b0;
      z_eff_r            <= Z_RESET;
      a_eff_r            <= A_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATERIAL_PRESENT: material_present_r <= cfg_wdata[0];
        REG_Z_EFF:            z_eff_r <= cfg_wdata[Z_BITS-1:0];
        REG_A_EFF:            a_eff_r <= cfg_wdata[A_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign z_clip = (z_eff_r < Z_BITS'(ZA_MIN)) ? Z_BITS'(ZA_MIN) : z_eff_r;
  assign a_clip = (a_eff_r < A_BITS'(ZA_MIN)) ? A_BITS'(ZA_MIN) : a_eff_r;

  // stage valids and per-stage advance
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NSTAGE; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTAGE-1];

  // special-case flags ride along with the request
  lnf_flags_t fl_r [ST_OUT];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fl_r[0].no_mat <= !material_present_r;
      fl_r[0].zero   <= (in_recoil_energy == '0);
    end
    for (int s = 1; s < ST_OUT; s++) begin
      if (en[s]) fl_r[s] <= fl_r[s-1];
    end
  end

  // logs of E, Z and A
  logic [ELG_W-1:0] lge;
  logic [ZLG_W-1:0] lgz;
  logic [ALG_W-1:0] lga;

  lnf_log #(.W(ENERGY_BITS)) u_log_e (
    .clk (clk), .en(en[LOG_STAGES-1:0]), .x_i(in_recoil_energy), .lg_o(lge)
  );
  lnf_log #(.W(Z_BITS)) u_log_z (
    .clk (clk), .en(en[LOG_STAGES-1:0]), .x_i(z_clip), .lg_o(lgz)
  );
  lnf_log #(.W(A_BITS)) u_log_a (
    .clk (clk), .en(en[LOG_STAGES-1:0]), .x_i(a_clip), .lg_o(lga)
  );

  // remove fixed-point scale
  logic signed [LW-1:0] le_r;
  logic [ZLG_W-1:0]     lz_r;
  logic [ALG_W-1:0]     la_h_r;

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      le_r   <= LW'(lge) - LW'(ENERGY_FRAC * LOG_ONE);
      lz_r   <= lgz - ZLG_W'(ZA_FRAC * LOG_ONE);
      la_h_r <= (lga - ALG_W'(ZA_FRAC * LOG_ONE)) >> 1;
    end
  end

  // constant dividers: reciprocal multiply, then one correction step
  logic [CD_W-1:0] cd_x [4];
  logic [CD_W-1:0] cd_q [4];
  logic [CD_W-1:0] m3_r;

  assign cd_x[0] = CD_W'(lz_r) * CD_W'(Z_EPS_NUM);
  assign cd_x[1] = CD_W'(lz_r) * CD_W'(Z_K_NUM);
  assign cd_x[2] = m3_r;
  assign cd_x[3] = m3_r;

  for (genvar g = 0; g < 4; g++) begin : g_cdiv
    localparam int D  = (g == 0) ? Z_EPS_DEN : (g == 1) ? Z_K_DEN :
                        (g == 2) ? EPS_A_DEN : EPS_B_DEN;
    localparam int SA = (g < 2) ? ST_CD1 : ST_CD2;
    localparam logic [CD_W-1:0] RECIP = CD_W'((64'd1 << CD_W) / D);

    logic [2*CD_W-1:0] prod;
    logic [CD_W-1:0]   q0_r;
    logic [CD_W-1:0]   x_r;
    logic [CD_W-1:0]   q_r;
    logic [CD_W-1:0]   r;

    assign prod = (2*CD_W)'(cd_x[g]) * (2*CD_W)'(RECIP);

    always_ff @(posedge clk) begin
      if (en[SA]) begin
        q0_r <= prod[2*CD_W-1:CD_W];
        x_r  <= cd_x[g];
      end
    end

    // estimate is at most one low
    assign r = x_r - q0_r * CD_W'(D);

    always_ff @(posedge clk) begin
      if (en[SA+1]) q_r <= (r >= CD_W'(D)) ? q0_r + CD_W'(1) : q0_r;
    end

    assign cd_q[g] = q_r;
  end

  logic signed [LW-1:0] le_c_r  [2];
  logic [ALG_W-1:0]     lah_c_r [2];

  always_ff @(posedge clk) begin
    if (en[ST_CD1]) begin
      le_c_r[0]  <= le_r;
      lah_c_r[0] <= la_h_r;
    end
    if (en[ST_CD1+1]) begin
      le_c_r[1]  <= le_c_r[0];
      lah_c_r[1] <= lah_c_r[0];
    end
  end

  // log epsilon and log k
  logic signed [LW-1:0] leps_r;
  logic signed [LW-1:0] lk_r;

  always_ff @(posedge clk) begin
    if (en[ST_EPS]) begin
      leps_r <= le_c_r[1] + LW'(LG_EPS) - LW'(cd_q[0]);
      lk_r   <= LW'(LG_K) + LW'(cd_q[1]) - LW'(lah_c_r[1]);
    end
  end

  // magnitude of 3*leps so the dividers truncate toward zero
  logic [LW-1:0]        t3;
  logic signed [LW-1:0] leps_c_r [3];
  logic signed [LW-1:0] lk_c_r   [3];
  logic                 neg_c_r  [3];

  assign t3 = leps_r * LW'(EPS_A_NUM);

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      m3_r        <= CD_W'(leps_r[LW-1] ? -t3 : t3);
      leps_c_r[0] <= leps_r;
      lk_c_r[0]   <= lk_r;
      neg_c_r[0]  <= leps_r[LW-1];
    end
    for (int s = 1; s < 3; s++) begin
      if (en[ST_ABS+s]) begin
        leps_c_r[s] <= leps_c_r[s-1];
        lk_c_r[s]   <= lk_c_r[s-1];
        neg_c_r[s]  <= neg_c_r[s-1];
      end
    end
  end

  // exponents of the three terms of k*h
  logic signed [LW-1:0] s5;
  logic signed [LW-1:0] s20;
  logic signed [LW-1:0] arg_r [3];

  assign s5  = neg_c_r[2] ? -LW'(cd_q[2]) : LW'(cd_q[2]);
  assign s20 = neg_c_r[2] ? -LW'(cd_q[3]) : LW'(cd_q[3]);

  always_ff @(posedge clk) begin
    if (en[ST_ARG]) begin
      arg_r[0] <= lk_c_r[2] + LW'(LG_07) + s5;
      arg_r[1] <= lk_c_r[2] + LW'(LG_3) + s20;
      arg_r[2] <= lk_c_r[2] + leps_c_r[2];
    end
  end

  // exp2 lanes: polynomial over three stages, then shift and saturate
  logic [EXP_W-1:0] ex [3];

  for (genvar j = 0; j < 3; j++) begin : g_exp
    logic [NW-1:0]       n_r [3];
    logic [LOG_FRAC-1:0] f_r [2];
    logic [LOG_FRAC-1:0] t_r [2];
    logic [P_W-1:0]      p_r;
    logic [EXP_W-1:0]    ex_r;
    logic [EXP_W-1:0]    ex_nxt;
    logic signed [NW:0]  sh;
    logic [NW:0]         nsh;

    always_ff @(posedge clk) begin
      if (en[ST_EXP]) begin
        n_r[0] <= arg_r[j][LW-1:LOG_FRAC];
        f_r[0] <= arg_r[j][LOG_FRAC-1:0];
        t_r[0] <= LOG_FRAC'((32'(arg_r[j][LOG_FRAC-1:0]) * 32'(POLY_A)) >> LOG_FRAC);
      end
      if (en[ST_EXP+1]) begin
        n_r[1] <= n_r[0];
        f_r[1] <= f_r[0];
        t_r[1] <= LOG_FRAC'(((32'(t_r[0]) + 32'(POLY_B)) * 32'(f_r[0])) >> LOG_FRAC);
      end
      if (en[ST_EXP+2]) begin
        n_r[2] <= n_r[1];
        p_r    <= P_W'(((32'(t_r[1]) + 32'(POLY_C)) * 32'(f_r[1])) >> LOG_FRAC)
                  + P_W'(LOG_ONE);
      end
      if (en[ST_EXP+3]) ex_r <= ex_nxt;
    end

    assign sh  = $signed({n_r[2][NW-1], n_r[2]}) + (NW+1)'(EXP_SH_OFS);
    assign nsh = -sh;

    always_comb begin
      if (sh > $signed((NW+1)'(EXP_SH_MAX))) begin
        ex_nxt = EXP_W'(1) << EXP_CAP_BIT;
      end else if (!sh[NW]) begin
        ex_nxt = EXP_W'(p_r) << sh[5:0];
      end else if (nsh >= (NW+1)'(P_W)) begin
        ex_nxt = '0;
      end else begin
        ex_nxt = EXP_W'(p_r >> nsh);
      end
    end

    assign ex[j] = ex_r;
  end

  // denominator 1 + k*h in Q32
  logic [DW-1:0] d_r;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      d_r <= (DW'(1) << D_ONE_BIT) + DW'(ex[0]) + DW'(ex[1]) + DW'(ex[2]);
    end
  end

  logic [F:0] div_q;
  logic       div_rnz;

  lnf_div #(.F(F)) u_div (
    .clk      (clk),
    .en       (en[ST_DIV+F:ST_DIV]),
    .d_i      (d_r),
    .q_o      (div_q),
    .rem_nz_o (div_rnz)
  );

  // output register
  logic [F:0] frac_r;
  logic       nm_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (fl_r[ST_OUT-1].no_mat) begin
        frac_r <= ONE;
        nm_r   <= 1'b1;
      end else if (fl_r[ST_OUT-1].zero) begin
        frac_r <= '0;
        nm_r   <= 1'b0;
      end else begin
        frac_r <= ONE - (div_q + (F+1)'(div_rnz));
        nm_r   <= 1'b0;
      end
    end
  end

  assign out_niel_fraction = frac_r;
  assign out_no_material   = nm_r;

  a_ready_follows_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while receiver takes results");

  a_no_material_one : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_material |-> out_niel_fraction == ONE)
    else $error("no_material result not forced to one");

  a_fraction_below_one : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_material |-> out_niel_fraction < ONE)
    else $error("fraction reached one with material present");

  a_bubble_closes : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ST_DIV-1] && !v_r[ST_DIV] |=> v_r[ST_DIV])
    else $error("request failed to advance into an empty stage");

endmodule
